[rtl/atsc_pkg.sv]
package atsc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned JOB_COUNT_W = 13;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COARSEN_FACTOR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEP       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEP       = 3'd4;

  localparam logic [31:0] COEF_Q32 = 32'd357770776;
  localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;

  localparam logic [31:0] RESET_TOLERANCE      = 32'd4294967;
  localparam logic [31:0] RESET_COARSEN_FACTOR = 32'h8000_0000;
  localparam logic [7:0]  RESET_REPEAT_COUNT   = 8'd3;
  localparam logic [31:0] RESET_MAX_STEP       = 32'hFFFF_FFFF;
  localparam logic [31:0] RESET_MIN_STEP       = 32'd0;

  typedef struct packed {
    logic [63:0]            diff_sum;
    logic [63:0]            sol_sum;
    logic [JOB_COUNT_W-1:0] count;
    logic [31:0]            step_size;
  } job_t;

  typedef struct packed {
    logic [31:0] tolerance;
    logic [31:0] coarsen_factor;
    logic [7:0]  repeat_count;
    logic [31:0] max_step;
    logic [31:0] min_step;
  } cfg_t;

endpackage

[rtl/atsc_fifo.sv]
module atsc_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  atsc_pkg::job_t                  push_data,
  input  logic                            pop,
  output atsc_pkg::job_t                  head,
  output logic [atsc_pkg::QCOUNT_W-1:0]   count
);
  import atsc_pkg::*;

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/atsc_front.sv]
module atsc_front #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [23:0]                   accel_now,
  input  logic [23:0]                   accel_prev,
  input  logic [23:0]                   solution_value,
  input  logic [31:0]                   step_size,
  input  logic                          last_element,
  input  logic [atsc_pkg::QCOUNT_W-1:0] q_count,
  output logic                          push,
  output atsc_pkg::job_t                push_data
);
  import atsc_pkg::*;

  localparam int unsigned ECOUNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DSQ_W    = 2 * SAMPLE_BITS + 2;
  localparam int unsigned SSQ_W    = 2 * SAMPLE_BITS;

  logic                        accept;
  logic                        counted;
  logic [ECOUNT_W-1:0]         ecount;
  logic [ECOUNT_W-1:0]         ecount_inc;
  logic signed [SAMPLE_BITS-1:0] a_now;
  logic signed [SAMPLE_BITS-1:0] a_prev;
  logic signed [SAMPLE_BITS:0]   diff;

  logic                          v1;
  logic                          add1;
  logic signed [SAMPLE_BITS:0]   d1;
  logic signed [SAMPLE_BITS-1:0] s1;
  logic                          last1;
  logic [31:0]                   dt1;
  logic [JOB_COUNT_W-1:0]        cnt1;

  logic                          v2;
  logic                          last2;
  logic [DSQ_W-1:0]              pd2;
  logic [SSQ_W-1:0]              ps2;
  logic [31:0]                   dt2;
  logic [JOB_COUNT_W-1:0]        cnt2;

  logic signed [DSQ_W-1:0]       pd;
  logic signed [SSQ_W-1:0]       ps;
  logic [63:0]                   dsum;
  logic [63:0]                   ssum;
  logic [63:0]                   dsum_next;
  logic [63:0]                   ssum_next;
  logic [QCOUNT_W+1:0]           pending;

  assign pending  = (QCOUNT_W + 2)'(q_count) + (QCOUNT_W + 2)'(v1 && last1)
                  + (QCOUNT_W + 2)'(v2 && last2);
  assign in_stall = (pending >= (QCOUNT_W + 2)'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  assign counted    = (ecount < ECOUNT_W'(MAX_ELEMENTS));
  assign ecount_inc = counted ? ecount + 1'b1 : ecount;
  assign a_now      = accel_now[SAMPLE_BITS-1:0];
  assign a_prev     = accel_prev[SAMPLE_BITS-1:0];
  assign diff       = {a_now[SAMPLE_BITS-1], a_now} - {a_prev[SAMPLE_BITS-1], a_prev};

  assign pd = d1 * d1;
  assign ps = s1 * s1;

  assign dsum_next = dsum + {{(64 - DSQ_W){1'b0}}, pd2};
  assign ssum_next = ssum + {{(64 - SSQ_W){1'b0}}, ps2};

  assign push                = v2 && last2;
  assign push_data.diff_sum  = dsum_next;
  assign push_data.sol_sum   = ssum_next;
  assign push_data.count     = cnt2;
  assign push_data.step_size = dt2;

  always_ff @(posedge clk) begin
    if (accept) begin
      add1  <= counted;
      d1    <= diff;
      s1    <= solution_value[SAMPLE_BITS-1:0];
      last1 <= last_element;
      dt1   <= step_size;
      cnt1  <= JOB_COUNT_W'(ecount_inc);
    end
    if (v1) begin
      last2 <= last1;
      pd2   <= add1 ? DSQ_W'(unsigned'(pd)) : '0;
      ps2   <= add1 ? SSQ_W'(unsigned'(ps)) : '0;
      dt2   <= dt1;
      cnt2  <= cnt1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      ecount <= '0;
      dsum   <= '0;
      ssum   <= '0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      if (accept) begin
        ecount <= last_element ? '0 : ecount_inc;
      end
      if (v2) begin
        dsum <= last2 ? '0 : dsum_next;
        ssum <= last2 ? '0 : ssum_next;
      end
    end
  end

endmodule

[rtl/atsc_back.sv]
module atsc_back (
  input  logic           clk,
  input  logic           rst,
  input  atsc_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  atsc_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           change_step,
  output logic [31:0]    new_step,
  output logic [31:0]    relative_error
);
  import atsc_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MUL   = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_SQRT  = 5'd3;
  localparam logic [4:0] S_MEAN  = 5'd4;
  localparam logic [4:0] S_RMS   = 5'd5;
  localparam logic [4:0] S_NORM  = 5'd6;
  localparam logic [4:0] S_P1    = 5'd7;
  localparam logic [4:0] S_P2    = 5'd8;
  localparam logic [4:0] S_P3    = 5'd9;
  localparam logic [4:0] S_REL   = 5'd10;
  localparam logic [4:0] S_BT    = 5'd11;
  localparam logic [4:0] S_FLAG  = 5'd12;
  localparam logic [4:0] S_CB0   = 5'd13;
  localparam logic [4:0] S_CB1   = 5'd14;
  localparam logic [4:0] S_CB2   = 5'd15;
  localparam logic [4:0] S_CB3   = 5'd16;
  localparam logic [4:0] S_STEP  = 5'd17;
  localparam logic [4:0] S_ST2   = 5'd18;
  localparam logic [4:0] S_CLAMP = 5'd19;

  logic [4:0]   state;
  logic [4:0]   ret;
  logic [6:0]   cnt;
  logic [127:0] x;
  logic [127:0] y;
  logic [63:0]  m;
  logic [64:0]  rem;

  job_t         job;
  logic [31:0]  rms;
  logic [31:0]  norm;
  logic [47:0]  peak;
  logic [47:0]  peak_next;
  logic [31:0]  rel;
  logic         flag;
  logic [7:0]   run;
  logic [7:0]   run_inc;
  logic [127:0] cnum;
  logic [31:0]  root;
  logic [31:0]  treg;
  logic [31:0]  tcand;
  logic [4:0]   bidx;
  logic [63:0]  step;
  logic [31:0]  step_sat;
  logic [31:0]  step_hi;
  logic [31:0]  step_out;

  logic [64:0]  div_rs;
  logic         div_ge;
  logic [64:0]  sq_rs;
  logic [64:0]  sq_trial;
  logic         sq_ge;

  assign pop = (state == S_IDLE) && !q_empty;

  assign div_rs   = {rem[63:0], x[127]};
  assign div_ge   = (div_rs >= {1'b0, m});
  assign sq_rs    = {rem[62:0], x[127:126]};
  assign sq_trial = {31'b0, y[31:0], 2'b01};
  assign sq_ge    = (sq_rs >= sq_trial);

  assign peak_next = ({16'b0, norm} > peak) ? {16'b0, norm} : peak;
  assign run_inc   = run + 1'b1;
  assign tcand     = root | (32'd1 << bidx);

  assign step_sat = (step[63:32] != 32'b0) ? SAT32 : step[31:0];
  assign step_hi  = (step_sat > cfg.max_step) ? cfg.max_step : step_sat;
  assign step_out = (step_hi < cfg.min_step) ? cfg.min_step : step_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
      peak      <= '0;
      run       <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_CLAMP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= head;
            x     <= {64'b0, head.diff_sum};
            m     <= (head.count == '0) ? 64'd1 : {51'b0, head.count};
            rem   <= '0;
            y     <= '0;
            cnt   <= '0;
            ret   <= S_MEAN;
            state <= S_DIV;
          end
        end
        S_MUL: begin
          if (m[0]) begin
            y <= y + x;
          end
          x   <= {x[126:0], 1'b0};
          m   <= {1'b0, m[63:1]};
          cnt <= cnt + 1'b1;
          if (cnt == 7'd63) begin
            state <= ret;
          end
        end
        S_DIV: begin
          rem <= div_ge ? div_rs - {1'b0, m} : div_rs;
          y   <= {y[126:0], div_ge};
          x   <= {x[126:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == 7'd127) begin
            state <= ret;
          end
        end
        S_SQRT: begin
          rem <= sq_ge ? sq_rs - sq_trial : sq_rs;
          y   <= {y[126:0], sq_ge};
          x   <= {x[125:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == 7'd31) begin
            state <= ret;
          end
        end
        S_MEAN: begin
          x     <= {y[55:0], 8'b0, 64'b0};
          rem   <= '0;
          y     <= '0;
          cnt   <= '0;
          ret   <= S_RMS;
          state <= S_SQRT;
        end
        S_RMS: begin
          rms   <= y[31:0];
          x     <= {job.sol_sum[59:0], 4'b0, 64'b0};
          rem   <= '0;
          y     <= '0;
          cnt   <= '0;
          ret   <= S_NORM;
          state <= S_SQRT;
        end
        S_NORM: begin
          norm  <= y[31:0];
          state <= S_P1;
        end
        S_P1: begin
          peak <= peak_next;
          x    <= {96'b0, job.step_size};
          m    <= {32'b0, job.step_size};
          y    <= '0;
          cnt  <= '0;
          if (peak_next == '0) begin
            rel   <= '0;
            state <= S_BT;
          end else if (norm == '0) begin
            rel   <= SAT32;
            state <= S_BT;
          end else begin
            ret   <= S_P2;
            state <= S_MUL;
          end
        end
        S_P2: begin
          x     <= {64'b0, y[63:0]};
          m     <= {32'b0, COEF_Q32};
          y     <= '0;
          cnt   <= '0;
          ret   <= S_P3;
          state <= S_MUL;
        end
        S_P3: begin
          x     <= {64'b0, y[95:32]};
          m     <= {32'b0, rms};
          y     <= '0;
          cnt   <= '0;
          ret   <= S_REL;
          state <= S_MUL;
        end
        S_REL: begin
          x     <= y;
          m     <= {6'b0, norm, 26'b0};
          rem   <= '0;
          y     <= '0;
          cnt   <= '0;
          ret   <= S_BT;
          state <= S_DIV;
        end
        S_BT: begin
          if (ret == S_BT) begin
            rel <= (y[127:32] != '0) ? SAT32 : y[31:0];
          end
          x     <= {96'b0, cfg.coarsen_factor};
          m     <= {32'b0, cfg.tolerance};
          y     <= '0;
          cnt   <= '0;
          ret   <= S_FLAG;
          state <= S_MUL;
        end
        S_FLAG: begin
          if ({rel, 8'b0} > {8'b0, cfg.tolerance}) begin
            run  <= '0;
            flag <= 1'b1;
          end else if (rel[31:24] != '0 || {rel, 40'b0} > {8'b0, y[63:0]}) begin
            run  <= '0;
            flag <= 1'b0;
          end else if (run_inc == cfg.repeat_count) begin
            run  <= '0;
            flag <= 1'b1;
          end else begin
            run  <= run_inc;
            flag <= 1'b0;
          end
          if (rel == '0) begin
            step  <= {31'b0, job.step_size, 1'b0} + {32'b0, job.step_size};
            state <= S_CLAMP;
          end else begin
            x     <= {32'b0, y[63:0], 32'b0};
            m     <= {32'b0, rel};
            rem   <= '0;
            y     <= '0;
            cnt   <= '0;
            ret   <= S_CB0;
            state <= S_DIV;
          end
        end
        S_CB0: begin
          cnum  <= y;
          root  <= '0;
          bidx  <= 5'd31;
          state <= S_CB1;
        end
        S_CB1: begin
          treg  <= tcand;
          x     <= {96'b0, tcand};
          m     <= {32'b0, tcand};
          y     <= '0;
          cnt   <= '0;
          ret   <= S_CB2;
          state <= S_MUL;
        end
        S_CB2: begin
          x     <= {64'b0, y[63:0]};
          m     <= {32'b0, treg};
          y     <= '0;
          cnt   <= '0;
          ret   <= S_CB3;
          state <= S_MUL;
        end
        S_CB3: begin
          if (y <= cnum) begin
            root <= treg;
          end
          if (bidx == '0) begin
            state <= S_STEP;
          end else begin
            bidx  <= bidx - 1'b1;
            state <= S_CB1;
          end
        end
        S_STEP: begin
          x     <= {96'b0, job.step_size};
          m     <= {32'b0, root};
          y     <= '0;
          cnt   <= '0;
          ret   <= S_ST2;
          state <= S_MUL;
        end
        S_ST2: begin
          step  <= y[87:24];
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            change_step    <= flag;
            new_step       <= step_out;
            relative_error <= rel;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (m != '0))
    else $error("division with zero divisor");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue read while empty");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (rem <= {y[63:0], 1'b0}))
    else $error("square root remainder out of range");

endmodule

[rtl/adaptive_time_step_controller.sv]
// Flow: the registered accumulate pipeline (difference and sample registers, then
// square registers) feeds the finishing engine per vector; the cube-root search
// (32 steps, two passes of the shared bit-serial multiplier each) dominates its work.
// Throughput: one element per cycle while in_stall is low; the engine takes the next
// vector when done with the last; up to four finished vectors wait between the halves.
// Reset (rst, synchronous): clears sums, counts, peak norm, run counter and queue,
// and loads the register defaults.
module adaptive_time_step_controller #(
  parameter int unsigned MAX_ELEMENTS = 4096,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [23:0]                        accel_now,
  input  logic [23:0]                        accel_prev,
  input  logic [23:0]                        solution_value,
  input  logic [31:0]                        step_size,
  input  logic                               last_element,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               change_step,
  output logic [31:0]                        new_step,
  output logic [31:0]                        relative_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [atsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data
);
  import atsc_pkg::*;

  cfg_t                cfg;
  logic                push;
  job_t                push_data;
  logic                pop;
  job_t                head;
  logic [QCOUNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance      <= RESET_TOLERANCE;
      cfg.coarsen_factor <= RESET_COARSEN_FACTOR;
      cfg.repeat_count   <= RESET_REPEAT_COUNT;
      cfg.max_step       <= RESET_MAX_STEP;
      cfg.min_step       <= RESET_MIN_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOLERANCE:      cfg.tolerance      <= cfg_data;
        REG_COARSEN_FACTOR: cfg.coarsen_factor <= cfg_data;
        REG_REPEAT_COUNT:   cfg.repeat_count   <= cfg_data[7:0];
        REG_MAX_STEP:       cfg.max_step       <= cfg_data;
        REG_MIN_STEP:       cfg.min_step       <= cfg_data;
        default:            cfg                <= cfg;
      endcase
    end
  end

  atsc_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .accel_now      (accel_now),
    .accel_prev     (accel_prev),
    .solution_value (solution_value),
    .step_size      (step_size),
    .last_element   (last_element),
    .q_count        (q_count),
    .push           (push),
    .push_data      (push_data)
  );

  atsc_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  atsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_count == '0),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .change_step    (change_step),
    .new_step       (new_step),
    .relative_error (relative_error)
  );

endmodule

[sim/adaptive_time_step_controller_tb.sv]
module adaptive_time_step_controller_tb;
  import atsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ELEM_LIMIT = 4096;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 12000;

  typedef struct packed {
    logic [23:0] accel_now;
    logic [23:0] accel_prev;
    logic [23:0] solution_value;
    logic [31:0] step_size;
    logic        last_element;
  } element_t;

  typedef struct packed {
    logic        change_step;
    logic [31:0] new_step;
    logic [31:0] relative_error;
  } step_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [23:0] accel_now;
  logic [23:0] accel_prev;
  logic [23:0] solution_value;
  logic [31:0] step_size;
  logic last_element;
  logic out_valid;
  logic out_stall;
  logic change_step;
  logic [31:0] new_step;
  logic [31:0] relative_error;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  adaptive_time_step_controller u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_now(accel_now), .accel_prev(accel_prev), .solution_value(solution_value),
    .step_size(step_size), .last_element(last_element),
    .out_valid(out_valid), .out_stall(out_stall),
    .change_step(change_step), .new_step(new_step), .relative_error(relative_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // controller state mirror
  logic [31:0] tol_q, beta_q, max_q, min_q;
  logic [7:0]  repeat_q;
  logic [63:0] diff_acc, sol_acc;
  logic [12:0] elem_cnt;
  logic [47:0] peak_q;
  logic [7:0]  small_run;

  element_t     pending_elements[$];
  step_result_t expected_steps[$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  int unsigned  hold_cycles;
  int unsigned  burst_left;
  int unsigned  gap_left;
  bit           in_taken;
  bit           hold_req;
  bit           timed_out;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] y, t;
    y = '0;
    for (int b = 31; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (t * t <= v) y = t;
    end
    return y;
  endfunction

  function automatic logic [63:0] icbrt(input logic [127:0] v);
    logic [63:0] y, t;
    logic [127:0] c;
    y = '0;
    for (int b = 31; b >= 0; b--) begin
      t = y | (64'd1 << b);
      c = 128'(t * t) * 128'(t);
      if (c <= v) y = t;
    end
    return y;
  endfunction

  function automatic logic signed [63:0] widen(input logic [23:0] v);
    return 64'(signed'(v));
  endfunction

  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_TOLERANCE:      tol_q = val;
      REG_COARSEN_FACTOR: beta_q = val;
      REG_REPEAT_COUNT:   repeat_q = val[7:0];
      REG_MAX_STEP:       max_q = val;
      REG_MIN_STEP:       min_q = val;
      default: ;
    endcase
  endtask

  task automatic predict_step(input element_t e);
    logic signed [63:0] d, s;
    logic [63:0] n, rms, norm, rel, bt, stepv, p48, f;
    logic [127:0] p, q;
    logic [127:0] num;
    logic flag;
    step_result_t r;
    flag = 1'b0;
    if (elem_cnt < ELEM_LIMIT) begin
      d = widen(e.accel_now) - widen(e.accel_prev);
      s = widen(e.solution_value);
      diff_acc += 64'(d * d);
      sol_acc += 64'(s * s);
      elem_cnt++;
    end
    if (!e.last_element) return;
    n = (elem_cnt != 0) ? 64'(elem_cnt) : 64'd1;
    rms = isqrt((diff_acc / n) << 8);
    norm = isqrt(sol_acc << 4);
    if (norm > 64'(peak_q)) peak_q = norm[47:0];
    if (peak_q == 0) rel = 0;
    else if (norm == 0) rel = 64'hFFFF_FFFF;
    else begin
      p = 128'(64'(e.step_size) * 64'(e.step_size)) * 128'(COEF_Q32);
      p48 = p[95:32];
      q = (128'(p48) * 128'(rms)) / 128'(norm << 26);
      rel = (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
    end
    bt = 64'(beta_q) * 64'(tol_q);
    if ((rel << 8) > 64'(tol_q)) begin
      small_run = 0;
      flag = 1'b1;
    end else if (rel >= (64'd1 << 24) || (rel << 40) > bt) begin
      small_run = 0;
    end else begin
      small_run = small_run + 8'd1;
      if (small_run == repeat_q) begin
        small_run = 0;
        flag = 1'b1;
      end
    end
    if (rel == 0) stepv = 64'(e.step_size) * 3;
    else begin
      num = {32'd0, bt, 32'd0};
      f = icbrt(num / 128'(rel));
      stepv = (64'(e.step_size) * f) >> 24;
    end
    if (stepv > 64'hFFFF_FFFF) stepv = 64'hFFFF_FFFF;
    if (stepv > 64'(max_q)) stepv = 64'(max_q);
    if (stepv < 64'(min_q)) stepv = 64'(min_q);
    r.change_step = flag;
    r.new_step = stepv[31:0];
    r.relative_error = rel[31:0];
    expected_steps.push_back(r);
    diff_acc = 0;
    sol_acc = 0;
    elem_cnt = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver: hold the transaction until the monitor has seen it taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_elements.size() > 0) begin
        element_t e;
        e = pending_elements[0];
        in_valid <= 1'b1;
        accel_now <= e.accel_now;
        accel_prev <= e.accel_prev;
        solution_value <= e.solution_value;
        step_size <= e.step_size;
        last_element <= e.last_element;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req) begin
      hold_cycles <= 30000;
      hold_req <= 1'b0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(7, 0) < 2);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        element_t e;
        e = pending_elements.pop_front();
        predict_step(e);
      end
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("unexpected result", new_step, 32'd0);
        end else begin
          step_result_t w;
          w = expected_steps.pop_front();
          if (change_step !== w.change_step)
            report_mismatch("change_step", 32'(change_step), 32'(w.change_step));
          if (new_step !== w.new_step)
            report_mismatch("new_step", new_step, w.new_step);
          if (relative_error !== w.relative_error)
            report_mismatch("relative_error", relative_error, w.relative_error);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_elements.size() != 0 || expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample(input int unsigned mode);
    case (mode)
      0: return 24'(signed'($urandom_range(64, 0)) - 32);
      1: return $urandom_range(1, 0) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_vector(input int unsigned len, input int unsigned mode,
                              input logic [31:0] dt);
    element_t e;
    for (int unsigned i = 0; i < len; i++) begin
      e.accel_now = rand_sample(mode);
      e.accel_prev = ($urandom_range(3, 0) == 0) ? e.accel_now : rand_sample(mode);
      e.solution_value = rand_sample(mode);
      e.step_size = ($urandom_range(1, 0)) ? dt : 32'($urandom);
      e.last_element = (i == len - 1);
      pending_elements.push_back(e);
    end
  endtask

  function automatic element_t make_element(input logic [23:0] an, input logic [23:0] ap,
                                            input logic [23:0] sv, input logic [31:0] dt,
                                            input logic lst);
    element_t e;
    e.accel_now = an;
    e.accel_prev = ap;
    e.solution_value = sv;
    e.step_size = dt;
    e.last_element = lst;
    return e;
  endfunction

  initial begin
    logic [31:0] dt;
    int unsigned count;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    accel_now = '0; accel_prev = '0; solution_value = '0;
    step_size = '0; last_element = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    tol_q = RESET_TOLERANCE; beta_q = RESET_COARSEN_FACTOR; repeat_q = RESET_REPEAT_COUNT;
    max_q = RESET_MAX_STEP; min_q = RESET_MIN_STEP;
    diff_acc = 0; sol_acc = 0; elem_cnt = 0; peak_q = 0; small_run = 0;
    mismatches = 0; idle_cycles = 0; burst_left = 0; gap_left = 0;
    hold_req = 0; timed_out = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero norm everywhere, then zero current norm with nonzero peak
    pending_elements.push_back(make_element(24'h0, 24'h0, 24'h0, 32'h0100_0000, 1'b1));
    pending_elements.push_back(make_element(24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                                            32'hFFFF_FFFF, 1'b1));
    pending_elements.push_back(make_element(24'h800000, 24'h7FFFFF, 24'h800000, 32'h0, 1'b0));
    pending_elements.push_back(make_element(24'h000001, 24'h0, 24'h010000, 32'h0100_0000, 1'b1));
    pending_elements.push_back(make_element(24'h123456, 24'h0, 24'h0, 32'h0200_0000, 1'b1));
    pending_elements.push_back(make_element(24'h0, 24'h0, 24'h7FFFFF, 32'hFFFF_FFFF, 1'b1));
    pending_elements.push_back(make_element(24'h000010, 24'h000010, 24'h400000,
                                            32'h0001_0000, 1'b1));
    for (int i = 0; i < 5; i++)
      pending_elements.push_back(make_element(24'h000002, 24'h000001, 24'h7FFFFF,
                                              32'h0000_1000, 1'b1));
    wait_drained();

    // clamp, zero coarsen product and wrap of the repeat counter
    write_register(REG_COARSEN_FACTOR, 32'd0);
    write_register(REG_MIN_STEP, 32'h0300_0000);
    write_register(REG_MAX_STEP, 32'h0200_0000);
    write_register(REG_REPEAT_COUNT, 8'd1);
    write_register(REG_TOLERANCE, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++)
      pending_elements.push_back(make_element(24'h000004, 24'h0, 24'h7FFFFF,
                                              32'h0100_0000, 1'b1));
    pending_elements.push_back(make_element(24'h0, 24'h0, 24'h0, 32'h0100_0000, 1'b1));
    wait_drained();

    // random full-width samples with a zero repeat count
    write_register(REG_MIN_STEP, 32'd0);
    write_register(REG_MAX_STEP, 32'hFFFF_FFFF);
    write_register(REG_COARSEN_FACTOR, 32'hFFFF_FFFF);
    write_register(REG_REPEAT_COUNT, 8'd0);
    queue_vector(8, 2, 32'h0080_0000);
    wait_drained();

    count = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_register(REG_TOLERANCE, (phase == 0) ? 32'd0 : 32'($urandom));
      write_register(REG_COARSEN_FACTOR, (phase == 1) ? 32'hFFFF_FFFF : 32'($urandom));
      write_register(REG_REPEAT_COUNT, (phase == 2) ? 8'd255 : 8'($urandom_range(4, 1)));
      write_register(REG_MAX_STEP, (phase == 3) ? 32'd0 : 32'($urandom) | 32'h8000_0000);
      write_register(REG_MIN_STEP, (phase == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(65535, 0)));
      if (phase == 2) hold_req = 1'b1;
      while (count < 150 * (phase + 1)) begin
        int unsigned len;
        dt = 32'($urandom);
        if ($urandom_range(1, 0)) dt = dt >> $urandom_range(28, 0);
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(4, 1);
        queue_vector(len, $urandom_range(2, 0), dt);
        count += len;
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
